// File: rtl/arfo_pkg.sv
// ============================================================================
// arfo_pkg: shared types and constants for the angular rate block
// Field widths, item structures and the fixed-point constants used by the
// channel interfaces and the datapath.
// ============================================================================
package arfo_pkg;

  localparam int TIME_W = 32;
  localparam int QUAT_W = 16;
  localparam int RATE_W = 24;

  // Serial datapath widths.
  localparam int ACC_W  = 56;   // multiplier accumulator and multiplicand
  localparam int MP_W   = 21;   // two's complement multiplier, one bit per cycle
  localparam int PROD_W = 32;   // quaternion component product
  localparam int MAT_W  = 35;   // matrix entry before rounding, Q28
  localparam int DIFF_W = 17;   // current minus previous matrix entry
  localparam int DVD_W  = 39;   // dividend of the rate division
  localparam int CNT_W  = 6;

  localparam logic [MP_W-1:0]  US_PER_S = MP_W'(1000000);
  localparam logic [MAT_W-1:0] ONE_Q28  = MAT_W'(1) << 28;
  localparam logic [QUAT_W-1:0] ONE_Q14 = QUAT_W'(16384);

  typedef struct packed {
    logic [TIME_W-1:0]        time_us;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
  } in_item_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic                     rate_valid;
  } out_item_t;

endpackage

// File: rtl/arfo_in_if.sv
// ============================================================================
// arfo_in_if: orientation sample channel
// Valid/ready channel carrying one timestamped quaternion per item.
// ============================================================================
interface arfo_in_if
  import arfo_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/arfo_out_if.sv
// ============================================================================
// arfo_out_if: angular rate result channel
// Valid/ready channel carrying one rate estimate per item.
// ============================================================================
interface arfo_out_if
  import arfo_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/angular_rate_from_orientation.sv
// No rate is computed when the time step is one microsecond or less. The next
// item is taken in the cycle after the result is loaded into the output register.
// One bit-serial multiplier (21 steps a product) and a 39-step divider do the
// arithmetic.
// Reset (synchronous, rst_n low) restores the identity matrix and time zero.
// ============================================================================
// angular_rate_from_orientation: body rate from successive quaternions
// Converts each quaternion to a rotation matrix, differences it against the
// stored matrix and, when a rate is due, divides by the time step, one bit per cycle.
// ============================================================================
module angular_rate_from_orientation
  import arfo_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  arfo_in_if.sink    in_ch,
  arfo_out_if.source out_ch
);

  // Sequencer states. Each multiply has a load state followed by MP_W shift
  // steps; the divider runs DVD_W steps after its own load state.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_QLD  = 4'd1;
  localparam logic [3:0] S_QMUL = 4'd2;
  localparam logic [3:0] S_MAT  = 4'd3;
  localparam logic [3:0] S_NLD  = 4'd4;
  localparam logic [3:0] S_NMUL = 4'd5;
  localparam logic [3:0] S_CLD  = 4'd6;
  localparam logic [3:0] S_CMUL = 4'd7;
  localparam logic [3:0] S_DLD  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  // The numerator terms are visited in a fixed order: rate x uses the
  // derivative of row 2 against row 1, rate y row 0 against row 2 and rate z
  // row 1 against row 0, three columns each. These tables give, for each
  // term, which matrix entry is differenced and which one multiplies it.
  localparam int DSEL [9] = '{6, 7, 8, 0, 1, 2, 3, 4, 5};
  localparam int RSEL [9] = '{3, 4, 5, 6, 7, 8, 0, 1, 2};

  logic [3:0]               state_r;
  logic [TIME_W-1:0]        prev_time_r;
  logic                     seen_r;
  logic [TIME_W-1:0]        dt_r;
  logic                     vld_r;
  logic signed [QUAT_W-1:0] qw_r, qx_r, qy_r, qz_r;
  logic [3:0]               pidx_r;
  logic [1:0]               k_r;
  logic [1:0]               ridx_r;
  logic [CNT_W-1:0]         cnt_r;

  logic signed [ACC_W-1:0]  mc_r;
  logic [MP_W-1:0]          mp_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     neg_r;
  logic [DVD_W-1:0]         dvd_r;
  logic [TIME_W-1:0]        rem_r;

  logic signed [PROD_W-1:0] prod_r [9];
  logic signed [QUAT_W-1:0] prev_r [9];
  logic signed [DIFF_W-1:0] dq_r   [9];
  logic signed [QUAT_W-1:0] rq_r   [9];
  logic signed [RATE_W-1:0] rate_r [3];

  logic                     out_valid_r;
  out_item_t                out_data_r;

  // Q28 value to Q14, rounding half up, saturated to 16 bits.
  function automatic logic signed [QUAT_W-1:0] q28_to_q14(
    input logic signed [MAT_W-1:0] v
  );
    logic signed [MAT_W-1:0] s;
    logic signed [MAT_W-15:0] r;
    s = v + MAT_W'(8192);
    r = s[MAT_W-1:14];
    if (r > (MAT_W-14)'(32767)) begin
      q28_to_q14 = QUAT_W'(32767);
    end else if (r < -(MAT_W-14)'(32768)) begin
      q28_to_q14 = QUAT_W'(-32768);
    end else begin
      q28_to_q14 = r[QUAT_W-1:0];
    end
  endfunction

  function automatic logic signed [MAT_W-1:0] px(input logic signed [PROD_W-1:0] p);
    px = {{(MAT_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  // ---- Shared serial multiplier step -------------------------------------
  // The multiplier is shifted out LSB first; its top bit carries negative
  // weight, so the last step subtracts.
  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W-1:0] acc_step;
  logic                    mul_last;

  assign mul_last = (cnt_r == CNT_W'(MP_W-1));
  assign addend   = mp_r[0] ? mc_r : '0;
  assign acc_step = mul_last ? (acc_r - addend) : (acc_r + addend);

  // ---- Quaternion product operands ----------------------------------------
  logic signed [QUAT_W-1:0] opa, opb;

  always_comb begin
    case (pidx_r)
      4'd0: begin opa = qx_r; opb = qx_r; end
      4'd1: begin opa = qy_r; opb = qy_r; end
      4'd2: begin opa = qz_r; opb = qz_r; end
      4'd3: begin opa = qx_r; opb = qy_r; end
      4'd4: begin opa = qx_r; opb = qz_r; end
      4'd5: begin opa = qy_r; opb = qz_r; end
      4'd6: begin opa = qw_r; opb = qx_r; end
      4'd7: begin opa = qw_r; opb = qy_r; end
      4'd8: begin opa = qw_r; opb = qz_r; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // ---- Rotation matrix from the stored products --------------------------
  // Products in order: xx yy zz xy xz yz wx wy wz, each still to be doubled.
  logic signed [QUAT_W-1:0] cur_c [9];

  always_comb begin
    cur_c[0] = q28_to_q14(ONE_Q28 - ((px(prod_r[1]) + px(prod_r[2])) <<< 1));
    cur_c[1] = q28_to_q14((px(prod_r[3]) - px(prod_r[8])) <<< 1);
    cur_c[2] = q28_to_q14((px(prod_r[4]) + px(prod_r[7])) <<< 1);
    cur_c[3] = q28_to_q14((px(prod_r[3]) + px(prod_r[8])) <<< 1);
    cur_c[4] = q28_to_q14(ONE_Q28 - ((px(prod_r[0]) + px(prod_r[2])) <<< 1));
    cur_c[5] = q28_to_q14((px(prod_r[5]) - px(prod_r[6])) <<< 1);
    cur_c[6] = q28_to_q14((px(prod_r[4]) - px(prod_r[7])) <<< 1);
    cur_c[7] = q28_to_q14((px(prod_r[5]) + px(prod_r[6])) <<< 1);
    cur_c[8] = q28_to_q14(ONE_Q28 - ((px(prod_r[0]) + px(prod_r[1])) <<< 1));
  end

  // ---- Divider step and rounding ------------------------------------------
  logic [TIME_W:0]          trial;
  logic [TIME_W+1:0]        trial_diff;
  logic                     qbit;
  logic [DVD_W-1:0]         quot;
  logic [ACC_W-1:0]         mag;
  logic [ACC_W-1:0]         rnd_sum;
  logic signed [RATE_W-1:0] rate_sat;

  assign trial      = {rem_r, dvd_r[DVD_W-1]};
  assign trial_diff = {1'b0, trial} - {2'b00, dt_r};
  assign qbit       = ~trial_diff[TIME_W+1];
  assign quot       = {dvd_r[DVD_W-2:0], qbit};
  assign mag        = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  // Adding half the divisor before the floor division gives rounding half
  // away from zero on the magnitude; the divisor is dt times 2^16.
  assign rnd_sum    = ACC_W'(acc_r) + {{(ACC_W-TIME_W-15){1'b0}}, dt_r, 15'b0};

  always_comb begin
    if (neg_r) begin
      if (quot > DVD_W'(8388608)) begin
        rate_sat = {1'b1, {(RATE_W-1){1'b0}}};
      end else begin
        rate_sat = RATE_W'(-quot[RATE_W-1:0]);
      end
    end else begin
      if (quot > DVD_W'(8388607)) begin
        rate_sat = {1'b0, {(RATE_W-1){1'b1}}};
      end else begin
        rate_sat = quot[RATE_W-1:0];
      end
    end
  end

  logic in_fire;
  logic out_load;
  logic [TIME_W-1:0] dt_in;

  // No item is taken while reset is held.
  assign in_ch.ready = rst_n && (state_r == S_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign dt_in       = in_ch.data.time_us - prev_time_r;

  // ---- Control state ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_time_r <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pidx_r      <= '0;
      k_r         <= '0;
      ridx_r      <= '0;
      cnt_r       <= '0;
      for (int i = 0; i < 9; i++) begin
        prev_r[i] <= (i % 4 == 0) ? ONE_Q14 : '0;
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            prev_time_r <= in_ch.data.time_us;
            seen_r      <= 1'b1;
            pidx_r      <= '0;
            state_r     <= S_QLD;
          end
        end
        S_QLD: begin
          cnt_r   <= '0;
          state_r <= S_QMUL;
        end
        S_QMUL: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (mul_last) begin
            if (pidx_r == 4'd8) begin
              state_r <= S_MAT;
            end else begin
              pidx_r  <= pidx_r + 4'd1;
              state_r <= S_QLD;
            end
          end
        end
        S_MAT: begin
          for (int i = 0; i < 9; i++) begin
            prev_r[i] <= cur_c[i];
          end
          k_r    <= '0;
          ridx_r <= '0;
          state_r <= vld_r ? S_NLD : S_DONE;
        end
        S_NLD: begin
          cnt_r   <= '0;
          state_r <= S_NMUL;
        end
        S_NMUL: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (mul_last) begin
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= S_CLD;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_NLD;
            end
          end
        end
        S_CLD: begin
          cnt_r   <= '0;
          state_r <= S_CMUL;
        end
        S_CMUL: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (mul_last) begin
            state_r <= S_DLD;
          end
        end
        S_DLD: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DVD_W-1)) begin
            if (ridx_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              ridx_r  <= ridx_r + 2'd1;
              state_r <= S_NLD;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // ---- Datapath -----------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          dt_r  <= dt_in;
          vld_r <= seen_r && (dt_in > TIME_W'(1));
          qw_r  <= in_ch.data.quat_w;
          qx_r  <= in_ch.data.quat_x;
          qy_r  <= in_ch.data.quat_y;
          qz_r  <= in_ch.data.quat_z;
        end
      end
      S_QLD: begin
        mc_r  <= {{(ACC_W-QUAT_W){opa[QUAT_W-1]}}, opa};
        mp_r  <= {{(MP_W-QUAT_W){opb[QUAT_W-1]}}, opb};
        acc_r <= '0;
      end
      S_QMUL, S_NMUL, S_CMUL: begin
        acc_r <= acc_step;
        mc_r  <= mc_r <<< 1;
        mp_r  <= mp_r >> 1;
        if (state_r == S_QMUL && mul_last) begin
          for (int i = 0; i < 8; i++) begin
            prod_r[i] <= prod_r[i+1];
          end
          prod_r[8] <= acc_step[PROD_W-1:0];
        end
      end
      S_MAT: begin
        for (int j = 0; j < 9; j++) begin
          dq_r[j] <= DIFF_W'(cur_c[DSEL[j]]) - DIFF_W'(prev_r[DSEL[j]]);
          rq_r[j] <= cur_c[RSEL[j]];
        end
        if (!vld_r) begin
          for (int i = 0; i < 3; i++) begin
            rate_r[i] <= '0;
          end
        end
      end
      S_NLD: begin
        mc_r <= {{(ACC_W-DIFF_W){dq_r[0][DIFF_W-1]}}, dq_r[0]};
        mp_r <= {{(MP_W-QUAT_W){rq_r[0][QUAT_W-1]}}, rq_r[0]};
        if (k_r == 2'd0) begin
          acc_r <= '0;
        end
        for (int i = 0; i < 8; i++) begin
          dq_r[i] <= dq_r[i+1];
          rq_r[i] <= rq_r[i+1];
        end
      end
      S_CLD: begin
        neg_r <= acc_r[ACC_W-1];
        mc_r  <= mag;
        mp_r  <= US_PER_S;
        acc_r <= '0;
      end
      S_DLD: begin
        dvd_r <= rnd_sum[DVD_W+15:16];
        rem_r <= '0;
      end
      S_DIV: begin
        rem_r <= qbit ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];
        dvd_r <= quot;
        if (cnt_r == CNT_W'(DVD_W-1)) begin
          rate_r[0] <= rate_r[1];
          rate_r[1] <= rate_r[2];
          rate_r[2] <= rate_sat;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_data_r.rate_x     <= rate_r[0];
          out_data_r.rate_y     <= rate_r[1];
          out_data_r.rate_z     <= rate_r[2];
          out_data_r.rate_valid <= vld_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // ---- Assertions ---------------------------------------------------------
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the completion state");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.rate_valid) |->
      (out_data_r.rate_x == '0 && out_data_r.rate_y == '0 && out_data_r.rate_z == '0))
    else $error("rates not zero on an item without a valid rate");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < dt_r))
    else $error("divider remainder not below the time step");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QMUL || state_r == S_NMUL || state_r == S_CMUL) |->
      (cnt_r < CNT_W'(MP_W)))
    else $error("multiplier step count overran");

endmodule
